[rtl/spcc_pkg.sv]
package spcc_pkg;

  localparam int MAX_PTS      = 1024;
  localparam int FRAC_BITS    = 16;
  localparam int CNT_W        = $clog2(MAX_PTS + 1);
  localparam int AW           = $clog2(MAX_PTS);
  localparam int SUM_W        = 32 + CNT_W - 1;
  localparam int PCNT_W       = 11;
  localparam int CORDIC_STEPS = 20;
  localparam int SQRT_STEPS   = 32;
  localparam int ITER_W       = $clog2(SUM_W);
  localparam int Z_W          = 26;
  localparam int CX_W         = 35;
  localparam int MUL_W        = 34;
  localparam int G_W          = 38;
  localparam int GAIN_Q30     = 652032874;
  localparam int PAD          = ((5 << FRAC_BITS) + 50) / 100;

  typedef enum logic [2:0] {
    REG_JOIN, REG_MINP, REG_CAP, REG_FLOOR, REG_CEIL, REG_YAW, REG_SX, REG_SY
  } cfg_reg_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_CINIT, OP_CSTEP, OP_GXH, OP_GXL, OP_GYH, OP_GYL,
    OP_WORLD, OP_JDIF, OP_SQX, OP_SQY, OP_JJD, OP_STORE, OP_DINITX, OP_DINITY,
    OP_DSTEP, OP_DENDX, OP_DENDY, OP_WINIT, OP_WDIF, OP_WMAX, OP_SQINIT,
    OP_SQSTEP, OP_RAD, OP_EMIT, OP_CLEAR
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_ROT, S_GXH, S_GXL, S_GYH, S_GYL, S_WORLD, S_JDIF, S_JSQX,
    S_JSQY, S_JJD, S_JCMP, S_STORE, S_POST, S_CLOSE, S_DIVX, S_DENDX, S_DINITY,
    S_DIVY, S_DENDY, S_WINIT, S_WRD, S_WDIF, S_WSQX, S_WSQY, S_WMAX, S_SQI,
    S_SQ, S_RAD, S_EMIT
  } ctl_state_t;

  typedef struct packed {
    dp_op_t              op;
    logic [ITER_W-1:0]   iter;
    logic                eos;
  } dp_cmd_t;

  typedef struct packed {
    logic kept;
    logic last;
    logic have_prev;
    logic join_ok;
    logic full;
    logic emit_ok;
    logic walk_last;
    logic out_free;
  } dp_stat_t;

  // arctangent of 2^-i in 2^-24 turn units
  function automatic logic signed [Z_W-1:0] atan_lut(input logic [4:0] i);
    logic signed [Z_W-1:0] v;
    begin
      case (i)
        5'd0:    v = 26'sd2097152;
        5'd1:    v = 26'sd1238021;
        5'd2:    v = 26'sd654136;
        5'd3:    v = 26'sd332050;
        5'd4:    v = 26'sd166669;
        5'd5:    v = 26'sd83416;
        5'd6:    v = 26'sd41718;
        5'd7:    v = 26'sd20860;
        5'd8:    v = 26'sd10430;
        5'd9:    v = 26'sd5215;
        5'd10:   v = 26'sd2608;
        5'd11:   v = 26'sd1304;
        5'd12:   v = 26'sd652;
        5'd13:   v = 26'sd326;
        5'd14:   v = 26'sd163;
        5'd15:   v = 26'sd81;
        5'd16:   v = 26'sd41;
        5'd17:   v = 26'sd20;
        5'd18:   v = 26'sd10;
        5'd19:   v = 26'sd5;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

[rtl/spcc_ctrl.sv]
module spcc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  spcc_pkg::dp_stat_t st,
  output spcc_pkg::dp_cmd_t  cmd
);
  import spcc_pkg::*;

  ctl_state_t        state_r, state_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              eos_r, eos_nxt;
  logic              ret_store_r, ret_store_nxt;
  ctl_state_t        ret_state;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iter_r      <= '0;
      eos_r       <= 1'b0;
      ret_store_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      eos_r       <= eos_nxt;
      ret_store_r <= ret_store_nxt;
    end
  end

  assign ret_state = ret_store_r ? S_STORE : S_IDLE;

  always_comb begin
    state_nxt     = state_r;
    iter_nxt      = iter_r;
    eos_nxt       = eos_r;
    ret_store_nxt = ret_store_r;
    cmd.op        = OP_NOP;
    cmd.iter      = iter_r;
    cmd.eos       = eos_r;
    in_ready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (st.kept) begin
          cmd.op    = OP_CINIT;
          iter_nxt  = '0;
          state_nxt = S_ROT;
        end else if (st.last && st.have_prev) begin
          eos_nxt       = 1'b1;
          ret_store_nxt = 1'b0;
          state_nxt     = S_CLOSE;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ROT: begin
        cmd.op = OP_CSTEP;
        if (iter_r == ITER_W'(CORDIC_STEPS - 1)) state_nxt = S_GXH;
        else iter_nxt = iter_r + 1'b1;
      end
      S_GXH: begin cmd.op = OP_GXH; state_nxt = S_GXL; end
      S_GXL: begin cmd.op = OP_GXL; state_nxt = S_GYH; end
      S_GYH: begin cmd.op = OP_GYH; state_nxt = S_GYL; end
      S_GYL: begin cmd.op = OP_GYL; state_nxt = S_WORLD; end
      S_WORLD: begin
        cmd.op    = OP_WORLD;
        state_nxt = st.have_prev ? S_JDIF : S_STORE;
      end
      S_JDIF: begin cmd.op = OP_JDIF; state_nxt = S_JSQX; end
      S_JSQX: begin cmd.op = OP_SQX;  state_nxt = S_JSQY; end
      S_JSQY: begin cmd.op = OP_SQY;  state_nxt = S_JJD; end
      S_JJD:  begin cmd.op = OP_JJD;  state_nxt = S_JCMP; end
      S_JCMP: begin
        if (st.join_ok) begin
          state_nxt = S_STORE;
        end else begin
          // close the open cluster, then come back to store this point
          eos_nxt       = 1'b0;
          ret_store_nxt = 1'b1;
          state_nxt     = S_CLOSE;
        end
      end
      S_STORE: begin cmd.op = OP_STORE; state_nxt = S_POST; end
      S_POST: begin
        if (st.full || st.last) begin
          eos_nxt       = st.last;
          ret_store_nxt = 1'b0;
          state_nxt     = S_CLOSE;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_CLOSE: begin
        if (st.emit_ok) begin
          cmd.op    = OP_DINITX;
          iter_nxt  = '0;
          state_nxt = S_DIVX;
        end else begin
          cmd.op    = OP_CLEAR;
          state_nxt = ret_state;
        end
      end
      S_DIVX: begin
        cmd.op = OP_DSTEP;
        if (iter_r == ITER_W'(SUM_W - 1)) state_nxt = S_DENDX;
        else iter_nxt = iter_r + 1'b1;
      end
      S_DENDX: begin cmd.op = OP_DENDX; state_nxt = S_DINITY; end
      S_DINITY: begin
        cmd.op    = OP_DINITY;
        iter_nxt  = '0;
        state_nxt = S_DIVY;
      end
      S_DIVY: begin
        cmd.op = OP_DSTEP;
        if (iter_r == ITER_W'(SUM_W - 1)) state_nxt = S_DENDY;
        else iter_nxt = iter_r + 1'b1;
      end
      S_DENDY: begin cmd.op = OP_DENDY; state_nxt = S_WINIT; end
      S_WINIT: begin cmd.op = OP_WINIT; state_nxt = S_WRD; end
      S_WRD:   begin state_nxt = S_WDIF; end
      S_WDIF:  begin cmd.op = OP_WDIF; state_nxt = S_WSQX; end
      S_WSQX:  begin cmd.op = OP_SQX;  state_nxt = S_WSQY; end
      S_WSQY:  begin cmd.op = OP_SQY;  state_nxt = S_WMAX; end
      S_WMAX: begin
        cmd.op    = OP_WMAX;
        state_nxt = st.walk_last ? S_SQI : S_WRD;
      end
      S_SQI: begin
        cmd.op    = OP_SQINIT;
        iter_nxt  = '0;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.op = OP_SQSTEP;
        if (iter_r == ITER_W'(SQRT_STEPS - 1)) state_nxt = S_RAD;
        else iter_nxt = iter_r + 1'b1;
      end
      S_RAD: begin cmd.op = OP_RAD; state_nxt = S_EMIT; end
      S_EMIT: begin
        // hold until the output register can take the result
        if (st.out_free) begin
          cmd.op    = OP_EMIT;
          state_nxt = ret_state;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[rtl/spcc_dp.sv]
module spcc_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_addr,
  input  logic [31:0]                 cfg_wdata,
  input  logic [31:0]                 beam_range,
  input  logic [15:0]                 beam_angle,
  input  logic                        not_finite,
  input  logic                        last_beam,
  input  spcc_pkg::dp_cmd_t           cmd,
  output spcc_pkg::dp_stat_t          st,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [31:0]                 mid_x,
  output logic [31:0]                 mid_y,
  output logic [31:0]                 radius,
  output logic [spcc_pkg::PCNT_W-1:0] point_count,
  output logic                        end_of_scan
);
  import spcc_pkg::*;

  // configuration
  logic [31:0]        join_r, cap_r, floor_r, ceil_r;
  logic [10:0]        minp_r;
  logic [15:0]        yaw_r;
  logic signed [31:0] sx_r, sy_r;

  // current beam
  logic [31:0] rng_r;
  logic [15:0] ang_r;
  logic        bad_r, last_r;

  // rotation and world point
  logic signed [CX_W-1:0] cx_r, cy_r;
  logic signed [Z_W-1:0]  cz_r;
  logic signed [G_W-1:0]  gx_r, gy_r;
  logic signed [31:0]     wx_r, wy_r, px_r, py_r;

  // shared multiplier
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p, p_r, gfull;

  logic [32:0] ux_r, uy_r;
  logic [65:0] sum2_r;

  // open cluster
  logic [31:0]             mem_x [MAX_PTS];
  logic [31:0]             mem_y [MAX_PTS];
  logic [31:0]             rdx_r, rdy_r;
  logic [CNT_W-1:0]        cnt_r, widx_r;
  logic signed [SUM_W-1:0] sum_x_r, sum_y_r;
  logic                    have_prev_r;

  // close: divider, walk, root
  logic [SUM_W-1:0]   quo_r;
  logic [CNT_W-1:0]   rem_r;
  logic               neg_r;
  logic signed [31:0] cen_x_r, cen_y_r;
  logic [63:0]        maxsq_r, sv_r, sres_r;
  logic [31:0]        rad_r;

  // output register
  logic                    out_valid_r, eos_r;
  logic [31:0]             ox_r, oy_r, orad_r;
  logic [PCNT_W-1:0]       ocnt_r;

  // combinational helpers
  logic [15:0]             a_sum, a_fold;
  logic                    fold;
  logic [4:0]              sh;
  logic signed [CX_W-1:0]  xs, ys;
  logic signed [Z_W-1:0]   atan_v;
  logic signed [38:0]      wsx, wsy;
  logic signed [32:0]      dx, dy;
  logic [SUM_W-1:0]        mag, dvd;
  logic signed [SUM_W-1:0] dsrc;
  logic [CNT_W:0]          t_div;
  logic                    ge;
  logic [63:0]             s64, one, sq_t;
  logic [5:0]              sq_sh;
  logic [32:0]             rsum;
  logic [31:0]             r32;

  function automatic logic signed [31:0] sat32(input logic signed [38:0] v);
    begin
      if (v > 39'sd2147483647) return 32'sh7FFFFFFF;
      else if (v < -39'sd2147483648) return 32'sh80000000;
      else return v[31:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      join_r  <= 32'd19661;
      minp_r  <= 11'd3;
      cap_r   <= 32'd131072;
      floor_r <= '0;
      ceil_r  <= '1;
      yaw_r   <= '0;
      sx_r    <= '0;
      sy_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_JOIN:  join_r  <= cfg_wdata;
        REG_MINP:  minp_r  <= cfg_wdata[10:0];
        REG_CAP:   cap_r   <= cfg_wdata;
        REG_FLOOR: floor_r <= cfg_wdata;
        REG_CEIL:  ceil_r  <= cfg_wdata;
        REG_YAW:   yaw_r   <= cfg_wdata[15:0];
        REG_SX:    sx_r    <= cfg_wdata;
        REG_SY:    sy_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_GXH: begin mul_a = MUL_W'(cx_r >>> 16);      mul_b = MUL_W'(GAIN_Q30); end
      OP_GXL: begin mul_a = {18'b0, cx_r[15:0]};      mul_b = MUL_W'(GAIN_Q30); end
      OP_GYH: begin mul_a = MUL_W'(cy_r >>> 16);      mul_b = MUL_W'(GAIN_Q30); end
      OP_GYL: begin mul_a = {18'b0, cy_r[15:0]};      mul_b = MUL_W'(GAIN_Q30); end
      OP_SQX: begin mul_a = {1'b0, ux_r};             mul_b = {1'b0, ux_r}; end
      OP_SQY: begin mul_a = {1'b0, uy_r};             mul_b = {1'b0, uy_r}; end
      OP_JJD: begin mul_a = {2'b0, join_r};           mul_b = {2'b0, join_r}; end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;
  assign gfull = (p_r <<< 16) + mul_p + 68'sd536870912;

  always_comb begin
    a_sum  = 16'(ang_r + yaw_r);
    fold   = (a_sum >= 16'h4000) && (a_sum < 16'hC000);
    a_fold = fold ? 16'(a_sum - 16'h8000) : a_sum;
    sh     = cmd.iter[4:0];
    xs     = cx_r >>> sh;
    ys     = cy_r >>> sh;
    atan_v = atan_lut(sh);
    wsx    = {{7{sx_r[31]}}, sx_r} + {gx_r[G_W-1], gx_r};
    wsy    = {{7{sy_r[31]}}, sy_r} + {gy_r[G_W-1], gy_r};
    if (cmd.op == OP_WDIF) begin
      dx = {rdx_r[31], rdx_r} - {cen_x_r[31], cen_x_r};
      dy = {rdy_r[31], rdy_r} - {cen_y_r[31], cen_y_r};
    end else begin
      dx = {wx_r[31], wx_r} - {px_r[31], px_r};
      dy = {wy_r[31], wy_r} - {py_r[31], py_r};
    end
    dsrc   = (cmd.op == OP_DINITY) ? sum_y_r : sum_x_r;
    mag    = dsrc[SUM_W-1] ? SUM_W'(-dsrc) : dsrc;
    dvd    = mag + SUM_W'(cnt_r >> 1);
    t_div  = {rem_r, quo_r[SUM_W-1]};
    ge     = t_div >= {1'b0, cnt_r};
    s64    = (|sum2_r[65:64]) ? '1 : sum2_r[63:0];
    sq_sh  = 6'd62 - {cmd.iter[4:0], 1'b0};
    one    = 64'd1 << sq_sh;
    sq_t   = sres_r + one;
    rsum   = {1'b0, sres_r[31:0]} + 33'(PAD);
    r32    = rsum[32] ? '1 : rsum[31:0];
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        rng_r  <= beam_range;
        ang_r  <= beam_angle;
        bad_r  <= not_finite;
        last_r <= last_beam;
      end
      OP_CINIT: begin
        cx_r <= fold ? -CX_W'(rng_r) : CX_W'(rng_r);
        cy_r <= '0;
        cz_r <= {{(Z_W - 24){a_fold[15]}}, a_fold, 8'h00};
      end
      OP_CSTEP: begin
        if (!cz_r[Z_W-1]) begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - atan_v;
        end else begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + atan_v;
        end
      end
      OP_GXH, OP_GYH, OP_SQX, OP_JJD: p_r <= mul_p;
      OP_GXL: gx_r <= gfull[2*MUL_W-1:30];
      OP_GYL: gy_r <= gfull[2*MUL_W-1:30];
      OP_WORLD: begin
        wx_r <= sat32(wsx);
        wy_r <= sat32(wsy);
      end
      OP_JDIF, OP_WDIF: begin
        ux_r <= dx[32] ? 33'(-dx) : dx;
        uy_r <= dy[32] ? 33'(-dy) : dy;
      end
      OP_SQY: sum2_r <= p_r[65:0] + mul_p[65:0];
      OP_STORE: begin
        px_r <= wx_r;
        py_r <= wy_r;
      end
      OP_DINITX, OP_DINITY: begin
        quo_r <= dvd;
        neg_r <= dsrc[SUM_W-1];
      end
      OP_DSTEP: begin
        rem_r <= ge ? CNT_W'(t_div - {1'b0, cnt_r}) : t_div[CNT_W-1:0];
        quo_r <= {quo_r[SUM_W-2:0], ge};
      end
      OP_DENDX: cen_x_r <= neg_r ? -quo_r[31:0] : quo_r[31:0];
      OP_DENDY: cen_y_r <= neg_r ? -quo_r[31:0] : quo_r[31:0];
      OP_WINIT: begin
        maxsq_r <= '0;
        widx_r  <= '0;
      end
      OP_WMAX: begin
        if (s64 > maxsq_r) maxsq_r <= s64;
        widx_r <= widx_r + 1'b1;
      end
      OP_SQINIT: begin
        sv_r   <= maxsq_r;
        sres_r <= '0;
      end
      OP_SQSTEP: begin
        if (sv_r >= sq_t) begin
          sv_r   <= sv_r - sq_t;
          sres_r <= (sres_r >> 1) + one;
        end else begin
          sres_r <= sres_r >> 1;
        end
      end
      OP_RAD: rad_r <= (r32 > cap_r) ? cap_r : r32;
      default: ;
    endcase
    // the divider remainder starts from zero on each init
    if (cmd.op == OP_DINITX || cmd.op == OP_DINITY) rem_r <= '0;
  end

  // point store
  always_ff @(posedge clk) begin
    if (cmd.op == OP_STORE) begin
      mem_x[cnt_r[AW-1:0]] <= wx_r;
      mem_y[cnt_r[AW-1:0]] <= wy_r;
    end
    rdx_r <= mem_x[widx_r[AW-1:0]];
    rdy_r <= mem_y[widx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      have_prev_r <= 1'b0;
    end else if (cmd.op == OP_STORE) begin
      cnt_r       <= cnt_r + 1'b1;
      sum_x_r     <= sum_x_r + {{(SUM_W - 32){wx_r[31]}}, wx_r};
      sum_y_r     <= sum_y_r + {{(SUM_W - 32){wy_r[31]}}, wy_r};
      have_prev_r <= 1'b1;
    end else if (cmd.op == OP_CLEAR || cmd.op == OP_EMIT) begin
      cnt_r       <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      have_prev_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      ox_r   <= cen_x_r;
      oy_r   <= cen_y_r;
      orad_r <= rad_r;
      ocnt_r <= PCNT_W'(cnt_r);
      eos_r  <= cmd.eos;
    end
  end

  assign st.kept      = !bad_r && (rng_r >= floor_r) && (rng_r <= ceil_r);
  assign st.last      = last_r;
  assign st.have_prev = have_prev_r;
  assign st.join_ok   = (ux_r < {1'b0, join_r}) && (uy_r < {1'b0, join_r}) &&
                        (sum2_r < p_r[65:0]);
  assign st.full      = cnt_r == CNT_W'(MAX_PTS);
  assign st.emit_ok   = (cnt_r != '0) && (32'(cnt_r) >= 32'(minp_r));
  assign st.walk_last = CNT_W'(widx_r + 1'b1) == cnt_r;
  assign st.out_free  = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign mid_x       = ox_r;
  assign mid_y       = oy_r;
  assign radius      = orad_r;
  assign point_count = ocnt_r;
  assign end_of_scan = eos_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_PTS))
    else $error("cluster count beyond buffer depth");

  a_prev_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    have_prev_r == (cnt_r != '0))
    else $error("open cluster flag disagrees with count");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_EMIT |-> (!out_valid_r || out_ready))
    else $error("result emitted over a pending result");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_EMIT |=> out_valid_r && cnt_r == '0)
    else $error("emit did not present result and clear cluster");

endmodule

[rtl/scan_point_cluster_circles_unit.sv]
// Channel | Dir | Payload (low bit first)                          | Handshake
// in_     | in  | tdata: beam_range, beam_angle; tuser: not_finite  | tvalid/tready
//         |     | tlast: last_beam                                  |
// out_    | out | tdata: mid_x, mid_y, radius, point_count          | tvalid/tready
//         |     | tlast: end_of_scan                                |
// cfg_    | in  | cfg_addr register index, cfg_wdata value          | cfg_we
//
// One beam at a time: a kept beam takes 20 rotation steps of the CORDIC unit, 5
// gain/offset steps and, with an open cluster, 5 join-test steps. Closing an
// emitted cluster runs the divider once per centroid coordinate, walks its
// points in the point memory through the shared multiplier, then forms the root,
// radius and emit; a cluster below min points closes with a clear and no output.
// The result waits in an output register; a stalled output holds the next close
// only. Reset is synchronous and needs no clearing pass.
module scan_point_cluster_circles_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [47:0]   in_tdata,   // beam_range[31:0], beam_angle[47:32]
  input  logic          in_tuser,   // not_finite
  input  logic          in_tlast,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [111:0]  out_tdata,  // mid_x, mid_y, radius, point_count, zero pad
  output logic          out_tlast,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_addr,
  input  logic [31:0]   cfg_wdata
);
  import spcc_pkg::*;

  dp_cmd_t             cmd;
  dp_stat_t            st;
  logic [31:0]         mid_x, mid_y, radius;
  logic [PCNT_W-1:0]   point_count;

  spcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  spcc_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .beam_range  (in_tdata[31:0]),
    .beam_angle  (in_tdata[47:32]),
    .not_finite  (in_tuser),
    .last_beam   (in_tlast),
    .cmd         (cmd),
    .st          (st),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .mid_x       (mid_x),
    .mid_y       (mid_y),
    .radius      (radius),
    .point_count (point_count),
    .end_of_scan (out_tlast)
  );

  assign out_tdata = {5'b0, point_count, radius, mid_y, mid_x};

endmodule
